/* hdl/fbmvn_pkg.sv */
package fbmvn_pkg;

   // shared multiplier operand width (signed), product is twice this
   localparam int MUL_W = 33;

   localparam logic [31:0] HASH_MUL   = 32'h45d9f3b7;
   localparam logic [31:0] SEED_STEP  = 32'd7919;
   localparam int          HASH_SHIFT = 16;

   // reciprocal of the total octave weight, Q.20, entry k serves k+1 octaves
   localparam int RECIP_W     = 21;
   localparam int RECIP_FRAC  = 20;
   localparam int RECIP_IDX_W = 4;
   localparam logic [RECIP_W-1:0] RECIP_TAB [2**RECIP_IDX_W] = '{
      21'd1048576, 21'd699051, 21'd599186, 21'd559241,
      21'd541201,  21'd532610, 21'd528416, 21'd526344,
      21'd525314,  21'd524801, 21'd524544, 21'd524416,
      21'd524352,  21'd524320, 21'd524304, 21'd524296
   };

   localparam int CSR_W = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HASH0A,
      ST_HASH0B,
      ST_HASH1A,
      ST_HASH1B,
      ST_SQUARE,
      ST_SMOOTH,
      ST_LERP,
      ST_ACCUM,
      ST_NORM_HI,
      ST_NORM_LO,
      ST_ROUND
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_HASH0A,
      OP_HASH0B,
      OP_HASH1A,
      OP_HASH1B,
      OP_SQUARE,
      OP_SMOOTH,
      OP_LERP,
      OP_ACCUM,
      OP_NORM_HI,
      OP_NORM_LO,
      OP_ROUND
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [RECIP_IDX_W-1:0] recip_idx;
   } cmd_type;

   // xor-shift step of the 32-bit hash mix, used before, between and after the multiplies
   function automatic logic [31:0] mix_xs(input logic [31:0] h);
      return h ^ (h >> HASH_SHIFT);
   endfunction

endpackage

/* hdl/fbmvn_ctrl.sv */
module fbmvn_ctrl #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [fbmvn_pkg::CSR_W-1:0] csr_write_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output fbmvn_pkg::cmd_type          cmd
);

   localparam int CW = $clog2(MAX_OCTAVES + 1);

   fbmvn_pkg::state_type        state_ff, state_in;
   logic [fbmvn_pkg::CSR_W-1:0] octave_count_ff, octave_count_in;
   logic [CW-1:0]               oct_left_ff, oct_left_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]               n_eff;
   logic                        out_free;
   logic                        req_xfer;

   // zero acts as one octave, counts above the maximum act as the maximum
   always_comb begin
      if (octave_count_ff == '0) begin
         n_eff = CW'(1);
      end else if ({1'b0, octave_count_ff} > 5'(MAX_OCTAVES)) begin
         n_eff = CW'(MAX_OCTAVES);
      end else begin
         n_eff = CW'(octave_count_ff);
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != fbmvn_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbmvn_pkg::ST_IDLE:    if (req_xfer) state_in = fbmvn_pkg::ST_HASH0A;
         fbmvn_pkg::ST_HASH0A:  state_in = fbmvn_pkg::ST_HASH0B;
         fbmvn_pkg::ST_HASH0B:  state_in = fbmvn_pkg::ST_HASH1A;
         fbmvn_pkg::ST_HASH1A:  state_in = fbmvn_pkg::ST_HASH1B;
         fbmvn_pkg::ST_HASH1B:  state_in = fbmvn_pkg::ST_SQUARE;
         fbmvn_pkg::ST_SQUARE:  state_in = fbmvn_pkg::ST_SMOOTH;
         fbmvn_pkg::ST_SMOOTH:  state_in = fbmvn_pkg::ST_LERP;
         fbmvn_pkg::ST_LERP:    state_in = fbmvn_pkg::ST_ACCUM;
         fbmvn_pkg::ST_ACCUM: begin
            if (oct_left_ff == CW'(1)) begin
               state_in = fbmvn_pkg::ST_NORM_HI;
            end else begin
               state_in = fbmvn_pkg::ST_HASH0A;
            end
         end
         fbmvn_pkg::ST_NORM_HI: state_in = fbmvn_pkg::ST_NORM_LO;
         fbmvn_pkg::ST_NORM_LO: state_in = fbmvn_pkg::ST_ROUND;
         fbmvn_pkg::ST_ROUND:   if (out_free) state_in = fbmvn_pkg::ST_IDLE;
         default:               state_in = fbmvn_pkg::ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd.recip_idx = fbmvn_pkg::RECIP_IDX_W'(n_eff - CW'(1));
      cmd.op        = fbmvn_pkg::OP_NONE;
      case (state_ff)
         fbmvn_pkg::ST_IDLE:    if (req_xfer) cmd.op = fbmvn_pkg::OP_START;
         fbmvn_pkg::ST_HASH0A:  cmd.op = fbmvn_pkg::OP_HASH0A;
         fbmvn_pkg::ST_HASH0B:  cmd.op = fbmvn_pkg::OP_HASH0B;
         fbmvn_pkg::ST_HASH1A:  cmd.op = fbmvn_pkg::OP_HASH1A;
         fbmvn_pkg::ST_HASH1B:  cmd.op = fbmvn_pkg::OP_HASH1B;
         fbmvn_pkg::ST_SQUARE:  cmd.op = fbmvn_pkg::OP_SQUARE;
         fbmvn_pkg::ST_SMOOTH:  cmd.op = fbmvn_pkg::OP_SMOOTH;
         fbmvn_pkg::ST_LERP:    cmd.op = fbmvn_pkg::OP_LERP;
         fbmvn_pkg::ST_ACCUM:   cmd.op = fbmvn_pkg::OP_ACCUM;
         fbmvn_pkg::ST_NORM_HI: cmd.op = fbmvn_pkg::OP_NORM_HI;
         fbmvn_pkg::ST_NORM_LO: cmd.op = fbmvn_pkg::OP_NORM_LO;
         fbmvn_pkg::ST_ROUND:   if (out_free) cmd.op = fbmvn_pkg::OP_ROUND;
         default:               cmd.op = fbmvn_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      octave_count_in = octave_count_ff;
      if (csr_write_enable) begin
         octave_count_in = csr_write_data;
      end

      oct_left_in = oct_left_ff;
      if (cmd.op == fbmvn_pkg::OP_START) begin
         oct_left_in = n_eff;
      end else if (cmd.op == fbmvn_pkg::OP_ACCUM) begin
         oct_left_in = oct_left_ff - CW'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == fbmvn_pkg::OP_ROUND) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= fbmvn_pkg::ST_IDLE;
         octave_count_ff <= fbmvn_pkg::CSR_W'(1);
         oct_left_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         octave_count_ff <= octave_count_in;
         oct_left_ff     <= oct_left_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

endmodule

/* hdl/fbmvn_dpath.sv */
module fbmvn_dpath #(
   parameter int MAX_OCTAVES = 8,
   parameter int FRAC_BITS   = 16
) (
   input  logic                       clock,
   input  fbmvn_pkg::cmd_type         cmd,
   input  logic signed [31:0]         req_coord,
   input  logic [31:0]                req_noise_seed,
   output logic signed [FRAC_BITS+1:0] rsp_noise_value
);

   localparam int MW    = fbmvn_pkg::MUL_W;
   localparam int XW    = 32 + FRAC_BITS;
   localparam int SW    = $clog2(MAX_OCTAVES + 1);
   localparam int ACC_W = FRAC_BITS + MAX_OCTAVES + 1;
   localparam int PW    = ACC_W + fbmvn_pkg::RECIP_W;
   localparam int SH    = MAX_OCTAVES - 1 + fbmvn_pkg::RECIP_FRAC;
   localparam int OUT_W = FRAC_BITS + 2;
   localparam int RQ_W  = PW - SH;
   localparam int ONE_I = 1 << FRAC_BITS;
   localparam logic signed [PW-1:0] HALF_LSB = PW'(1) << (SH - 1);

   // scaled coordinate, octave seed, weight shift, accumulators
   logic [XW-1:0]             xs_ff, xs_in;
   logic [31:0]               os_ff, os_in;
   logic [SW-1:0]             shamt_ff, shamt_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [FRAC_BITS-1:0]      v0_ff, v0_in;
   logic [FRAC_BITS-1:0]      v1_ff, v1_in;
   logic signed [PW-1:0]      fin_ff, fin_in;
   logic signed [2*MW-1:0]    prod_ff, prod_in;
   logic                      mul_en;
   logic signed [OUT_W-1:0]   out_ff, out_in;

   logic signed [MW-1:0]      mul_a, mul_b;
   logic [31:0]               ix;
   logic [FRAC_BITS-1:0]      t;
   logic [31:0]               hash_fin;
   logic [FRAC_BITS-1:0]      lat_val;
   logic [FRAC_BITS-1:0]      t2;
   logic [FRAC_BITS+1:0]      smooth_b;
   logic [FRAC_BITS:0]        s;
   logic signed [FRAC_BITS:0] diff;
   logic signed [FRAC_BITS+1:0] bsum;
   logic signed [FRAC_BITS+1:0] cval;
   logic signed [63:0]        acc_ext;
   logic signed [2*MW-1:0]    hi_shift;
   logic signed [PW-1:0]      rtot;
   logic signed [RQ_W-1:0]    rq;

   assign ix       = xs_ff[FRAC_BITS +: 32];
   assign t        = xs_ff[FRAC_BITS-1:0];
   assign hash_fin = fbmvn_pkg::mix_xs(prod_ff[31:0]);
   assign lat_val  = hash_fin[31 -: FRAC_BITS];
   assign t2       = prod_ff[2*FRAC_BITS-1:FRAC_BITS];
   assign smooth_b = (FRAC_BITS+2)'(3 * ONE_I) - {1'b0, t, 1'b0};
   assign s        = prod_ff[2*FRAC_BITS:FRAC_BITS];
   assign diff     = $signed({1'b0, v1_ff}) - $signed({1'b0, v0_ff});
   // floor of the interpolation step comes from the arithmetic shift
   assign bsum     = $signed({2'b00, v0_ff})
                     + (FRAC_BITS+2)'($signed(prod_ff[2*FRAC_BITS:FRAC_BITS]));
   assign cval     = $signed({1'b0, bsum[FRAC_BITS-1:0], 1'b0})
                     - $signed({2'b01, {FRAC_BITS{1'b0}}});
   assign acc_ext  = 64'(acc_ff);
   assign hi_shift = prod_ff <<< 32;
   assign rtot     = fin_ff + PW'(prod_ff) + HALF_LSB;
   assign rq       = rtot[PW-1:SH];

   always_comb begin
      xs_in    = xs_ff;
      os_in    = os_ff;
      shamt_in = shamt_ff;
      acc_in   = acc_ff;
      v0_in    = v0_ff;
      v1_in    = v1_ff;
      fin_in   = fin_ff;
      out_in   = out_ff;
      mul_en   = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      case (cmd.op)
         fbmvn_pkg::OP_START: begin
            xs_in    = XW'(req_coord);
            os_in    = req_noise_seed;
            shamt_in = SW'(MAX_OCTAVES - 1);
            acc_in   = '0;
         end
         fbmvn_pkg::OP_HASH0A: begin
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, fbmvn_pkg::mix_xs(ix ^ os_ff)});
            mul_b  = $signed({1'b0, fbmvn_pkg::HASH_MUL});
         end
         fbmvn_pkg::OP_HASH0B, fbmvn_pkg::OP_HASH1B: begin
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, fbmvn_pkg::mix_xs(prod_ff[31:0])});
            mul_b  = $signed({1'b0, fbmvn_pkg::HASH_MUL});
         end
         fbmvn_pkg::OP_HASH1A: begin
            v0_in  = lat_val;
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, fbmvn_pkg::mix_xs((ix + 32'd1) ^ os_ff)});
            mul_b  = $signed({1'b0, fbmvn_pkg::HASH_MUL});
         end
         fbmvn_pkg::OP_SQUARE: begin
            v1_in  = lat_val;
            mul_en = 1'b1;
            mul_a  = $signed(MW'(t));
            mul_b  = $signed(MW'(t));
         end
         fbmvn_pkg::OP_SMOOTH: begin
            mul_en = 1'b1;
            mul_a  = $signed(MW'(t2));
            mul_b  = $signed(MW'(smooth_b));
         end
         fbmvn_pkg::OP_LERP: begin
            mul_en = 1'b1;
            mul_a  = MW'(diff);
            mul_b  = $signed(MW'(s));
         end
         fbmvn_pkg::OP_ACCUM: begin
            acc_in   = acc_ff + (ACC_W'(cval) <<< shamt_ff);
            xs_in    = xs_ff << 1;
            os_in    = os_ff + fbmvn_pkg::SEED_STEP;
            shamt_in = shamt_ff - SW'(1);
         end
         fbmvn_pkg::OP_NORM_HI: begin
            // upper part of the sum first, lower 32 bits next
            mul_en = 1'b1;
            mul_a  = $signed({acc_ext[63], acc_ext[63:32]});
            mul_b  = $signed(MW'(fbmvn_pkg::RECIP_TAB[cmd.recip_idx]));
         end
         fbmvn_pkg::OP_NORM_LO: begin
            fin_in = PW'(hi_shift);
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, acc_ext[31:0]});
            mul_b  = $signed(MW'(fbmvn_pkg::RECIP_TAB[cmd.recip_idx]));
         end
         fbmvn_pkg::OP_ROUND: begin
            if (rq > ONE_I) begin
               out_in = OUT_W'(ONE_I);
            end else if (rq < -ONE_I) begin
               out_in = OUT_W'(-ONE_I);
            end else begin
               out_in = OUT_W'(rq);
            end
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      xs_ff    <= xs_in;
      os_ff    <= os_in;
      shamt_ff <= shamt_in;
      acc_ff   <= acc_in;
      v0_ff    <= v0_in;
      v1_ff    <= v1_in;
      fin_ff   <= fin_in;
      out_ff   <= out_in;
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign rsp_noise_value = out_ff;

endmodule

/* hdl/fbm_value_noise_1d.sv */
// One-dimensional fractal value noise. Each accepted transfer carries a signed
// Q16.16 coordinate (Q(32-FRAC_BITS).FRAC_BITS in general) and a 32-bit seed and
// yields one signed Q2.FRAC_BITS sample in [-1, +1]. The octave count written on
// csr_write_data selects how many octaves are summed (0 acts as 1, counts above
// MAX_OCTAVES act as MAX_OCTAVES) and may only be written while no item is in
// flight. The input stays stalled from acceptance until the item is done, as all
// hashing, smoothstep, blending and final normalization run through a single
// shared 33x33 multiplier, seven products per octave plus two for the
// normalization. The result sits in an output register, so a new item is
// accepted while the previous result is still waiting to be taken; the result
// register is overwritten only after the waiting result has been transferred.
module fbm_value_noise_1d #(
   parameter int MAX_OCTAVES = 8,
   parameter int FRAC_BITS   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [3:0]                  csr_write_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [31:0]          req_coord,
   input  logic [31:0]                 req_noise_seed,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [FRAC_BITS+1:0] rsp_noise_value
);

   fbmvn_pkg::cmd_type cmd;

   fbmvn_ctrl #(
      .MAX_OCTAVES(MAX_OCTAVES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd)
   );

   fbmvn_dpath #(
      .MAX_OCTAVES(MAX_OCTAVES),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock           (clock),
      .cmd             (cmd),
      .req_coord       (req_coord),
      .req_noise_seed  (req_noise_seed),
      .rsp_noise_value (rsp_noise_value)
   );

endmodule

/* hdl/fbmvn_checker.sv */
module fbmvn_checker #(
   parameter int FRAC_BITS = 16
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [FRAC_BITS+1:0] rsp_noise_value
);

   localparam int ONE_I = 1 << FRAC_BITS;

   // result stays within minus one to plus one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_noise_value) <= ONE_I)
                    && ($signed(rsp_noise_value) >= -ONE_I))
      else $error("noise value out of range");

   // an accepted item keeps the input side busy in the following cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after transfer");

   // a new result only shows up at the end of work on an item
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work in progress");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_noise_value))
      else $error("stalled result changed");

endmodule

bind fbm_value_noise_1d fbmvn_checker #(
   .FRAC_BITS(FRAC_BITS)
) u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_noise_value (rsp_noise_value)
);

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int FRAC_BITS   = 16;
   localparam int OUT_W       = FRAC_BITS + 2;
   localparam int MAX_OCT     = 8;
   localparam int RECIP_FRAC  = 20;
   localparam int NORM_SHIFT  = MAX_OCT - 1 + RECIP_FRAC;
   localparam int MAX_GAP     = 12;
   localparam int PHASES      = 16;
   localparam int PHASE_ITEMS = 102;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 200;
   localparam int MAX_REPORTS = 50;

   localparam logic [31:0] MIX_MUL   = 32'h45d9f3b7;
   localparam logic [31:0] OCT_SEED_STEP = 32'd7919;
   localparam longint      UNIT      = 64'sd1 << FRAC_BITS;

   typedef struct {
      logic signed [31:0]      coord;
      logic [31:0]             seed;
      logic signed [OUT_W-1:0] value;
   } noise_sample_type;

   class fbm_noise_scoreboard;
      logic [3:0]       octaves;
      longint           recip_q20 [MAX_OCT+1];
      noise_sample_type pending_noise [$];
      int               errors;
      int               checked;
      int               accepted;

      function new();
         longint den;
         octaves = 4'd1;
         errors = 0;
         checked = 0;
         accepted = 0;
         recip_q20[0] = 0;
         for (int k = 1; k <= MAX_OCT; k++) begin
            den = (64'sd1 << k) - 1;
            recip_q20[k] = ((64'sd1 << (k - 1 + RECIP_FRAC)) + den / 2) / den;
         end
      endfunction

      function void set_octaves(logic [3:0] v);
         octaves = v;
      endfunction

      function logic [31:0] mix_hash(logic [31:0] h);
         h = h ^ (h >> 16);
         h = h * MIX_MUL;
         h = h ^ (h >> 16);
         h = h * MIX_MUL;
         return h ^ (h >> 16);
      endfunction

      function logic signed [OUT_W-1:0] fbm_noise_of(logic signed [31:0] x, logic [31:0] seed);
         int n;
         longint sx, t, t2, s, v0, v1, blend, c, acc, prod, res;
         logic [31:0] ix, oct_seed;
         n = int'(octaves);
         if (n < 1) n = 1;
         if (n > MAX_OCT) n = MAX_OCT;
         acc = 0;
         for (int i = 0; i < n; i++) begin
            sx = longint'(x) <<< i;
            ix = sx[FRAC_BITS+31:FRAC_BITS];
            t = longint'(sx[FRAC_BITS-1:0]);
            oct_seed = seed + OCT_SEED_STEP * i;
            v0 = longint'(mix_hash(ix ^ oct_seed) >> (32 - FRAC_BITS));
            v1 = longint'(mix_hash((ix + 32'd1) ^ oct_seed) >> (32 - FRAC_BITS));
            // smoothstep 3t^2 - 2t^3 in fixed point
            t2 = (t * t) >> FRAC_BITS;
            s = (t2 * (3 * UNIT - 2 * t)) >> FRAC_BITS;
            blend = (v0 * (UNIT - s) + v1 * s) >> FRAC_BITS;
            c = 2 * blend - UNIT;
            acc = acc + c * (64'sd1 << (MAX_OCT - 1 - i));
         end
         prod = acc * recip_q20[n];
         res = (prod + (64'sd1 <<< (NORM_SHIFT - 1))) >>> NORM_SHIFT;
         if (res > UNIT) res = UNIT;
         if (res < -UNIT) res = -UNIT;
         return res[OUT_W-1:0];
      endfunction

      function void note_sample(logic signed [31:0] x, logic [31:0] seed);
         noise_sample_type e;
         e.coord = x;
         e.seed = seed;
         e.value = fbm_noise_of(x, seed);
         pending_noise.push_back(e);
         accepted++;
      endfunction

      function void report(string what);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s", $time, what);
         else if (errors == MAX_REPORTS + 1)
            $display("%0t: further mismatch reports suppressed", $time);
      endfunction

      function void check_sample(logic signed [OUT_W-1:0] actual);
         noise_sample_type e;
         if (pending_noise.size() == 0) begin
            report($sformatf("unexpected noise_value transfer, actual %0d", actual));
            return;
         end
         e = pending_noise.pop_front();
         checked++;
         if (actual !== e.value)
            report($sformatf("noise_value mismatch (coord %h seed %h): expected %0d, actual %0d",
                             e.coord, e.seed, e.value, actual));
      endfunction

      function int pending();
         return pending_noise.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   logic [3:0]              csr_write_data;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [31:0]      req_coord;
   logic [31:0]             req_noise_seed;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [OUT_W-1:0] rsp_noise_value;

   fbm_noise_scoreboard sb;
   bit                  idle_on;
   logic [15:0]         octaves_seen;

   fbm_value_noise_1d #(
      .MAX_OCTAVES(MAX_OCT),
      .FRAC_BITS  (FRAC_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_coord       (req_coord),
      .req_noise_seed  (req_noise_seed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_noise_value (rsp_noise_value)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // transfer monitor: results are checked before the same edge's input is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_sample(rsp_noise_value);
         if (req_valid === 1'b1 && req_stall === 1'b0)
            sb.note_sample(req_coord, req_noise_seed);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int draw_gap();
      return idle_on ? $urandom_range(0, MAX_GAP) : 0;
   endfunction

   // result side: stall either from now or from when the result shows up
   initial begin : result_sink
      int hold;
      @(negedge reset);
      forever begin
         hold = draw_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            if ($urandom_range(0, 1) == 1) begin
               do @(posedge clock); while (rsp_valid !== 1'b1);
               @(negedge clock);
            end
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         @(negedge clock);
      end
   end

   task automatic send_sample(input logic signed [31:0] x, input logic [31:0] seed);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_coord      <= x;
      req_noise_seed <= seed;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic stop_and_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_octaves(input logic [3:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_octaves(v);
      octaves_seen[v] = 1'b1;
   endtask

   function automatic logic signed [31:0] random_coord();
      logic [31:0] r;
      logic [15:0] frac_pick [5] = '{16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE, 16'h8000};
      r = $urandom;
      case ($urandom_range(0, 4))
         1: begin
            r = $urandom_range(0, 32'h3FFFF);
            if ($urandom_range(0, 1) == 1) r = -r;
         end
         // on, just beside or midway between lattice points
         2: r = {r[31:16], frac_pick[$urandom_range(0, 4)]};
         3: r = $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 255)
                                     : 32'h80000000 + $urandom_range(0, 255);
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] random_seed();
      case ($urandom_range(0, 11))
         0: return 32'h0;
         1: return 32'hFFFFFFFF;
         2: return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      logic [3:0] oct;
      int         n_settings;
      sb = new();
      octaves_seen = 16'h0;
      idle_on = 1'b1;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 4'd0;
      req_valid = 1'b0;
      req_coord = 32'sd0;
      req_noise_seed = 32'd0;
      rsp_stall = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // one octave out of reset, lattice index wrap at -1
      octaves_seen[1] = 1'b1;
      send_sample(32'sh00000000, 32'h00000000);
      send_sample(32'sh00008000, 32'hFFFFFFFF);
      send_sample(-32'sd1,       32'h12345678);
      send_sample(32'sh7FFFFFFF, 32'h00000000);
      stop_and_drain();

      write_octaves(4'd8);
      send_sample(32'sh00000000, 32'h00000000);
      send_sample(32'sh7FFFFFFF, 32'hFFFFFFFF);
      send_sample(32'sh80000000, 32'h00000000);
      send_sample(-32'sd1,       32'hAAAAAAAA);
      send_sample(32'sh00000001, 32'h55555555);
      send_sample(32'sh0000FFFF, 32'h00000001);
      send_sample(32'sh00010000, 32'h80000000);
      send_sample(32'shFFFF0000, 32'h7FFFFFFF);
      send_sample(32'sh00008000, 32'hDEADBEEF);
      send_sample(32'sh7FFF8000, 32'h00000000);
      send_sample(32'shFFFFFFFF, 32'hFFFFFFFF);
      send_sample(32'sh40000000, 32'h0F0F0F0F);
      stop_and_drain();

      // counts beyond the range clamp to one and to the maximum
      write_octaves(4'd0);
      send_sample(32'sh80000000, 32'hFFFFFFFF);
      send_sample(32'sh00018000, 32'h00000000);
      send_sample(-32'sd1,       32'h00000000);
      stop_and_drain();
      write_octaves(4'd15);
      send_sample(32'sh7FFFFFFF, 32'h12345678);
      send_sample(32'sh80000000, 32'h87654321);
      send_sample(32'sh00000000, 32'hFFFFFFFF);
      stop_and_drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: oct = 4'd1;
            1: oct = 4'd8;
            2: oct = 4'd0;
            3: oct = 4'd15;
            4: oct = 4'd9;
            default: oct = 4'($urandom_range(0, 15));
         endcase
         write_octaves(oct);
         idle_on = (p % 4 != 2);
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_sample(random_coord(), random_seed());
         stop_and_drain();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      n_settings = $countones(octaves_seen);
      $display("%0d samples sent under %0d octave settings, %0d results checked",
               sb.accepted, n_settings, sb.checked);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results still owed", sb.errors, sb.pending());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
